// File: hdl/ipk_pkg.sv
// Shared types, codes and constants for the iambic paddle keyer.
// No dependencies; imported by ipk_step and iambic_paddle_keyer.
package ipk_pkg;

    localparam int DIT_W   = 12;
    localparam int DAH_W   = 12;
    localparam int PTT_W   = 10;
    localparam int TMR_W   = 13;
    localparam int WST_W   = 12;
    localparam int MODE_W  = 2;
    localparam int EVT_W   = 2;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PTT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd3;

    // register reset values
    localparam logic [DIT_W-1:0] DIT_RESET = 12'd60;
    localparam logic [DAH_W-1:0] DAH_RESET = 12'd180;
    localparam logic [PTT_W-1:0] PTT_RESET = 10'd0;

    // keyer phases
    localparam logic [PHASE_W-1:0] PH_UP  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DIT = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DAH = 2'd2;

    // element events
    localparam logic [EVT_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVT_W-1:0] EVT_DIT   = 2'd1;
    localparam logic [EVT_W-1:0] EVT_DAH   = 2'd2;
    localparam logic [EVT_W-1:0] EVT_CHSPC = 2'd3;

    // delay before the first transition after reset, ms
    localparam logic [TMR_W-1:0] START_DELAY = 13'd100;

    typedef struct packed {
        logic [DIT_W-1:0] dit_ms;
        logic [DAH_W-1:0] dah_ms;
        logic [PTT_W-1:0] ptt_delay_ms;
        logic             reverse_paddles;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] keyer_phase;
        logic [PHASE_W-1:0] previous_phase;
        logic               dit_latch;
        logic               dah_latch;
        logic [TMR_W-1:0]   transition_timer;
        logic [TMR_W-1:0]   read_block_timer;
        logic [WST_W-1:0]   word_space_timer;
        logic               word_space_armed;
        logic               key_state;
    } keyer_ctx_t;

    typedef struct packed {
        logic              left_level;
        logic              right_level;
        logic [MODE_W-1:0] source_mode;
    } tick_t;

    typedef struct packed {
        logic              key_level;
        logic [EVT_W-1:0]  element_event;
        logic              word_space;
        logic [MODE_W-1:0] mode_out;
    } result_t;

endpackage

// File: hdl/ipk_step.sv
// Combinational step of the keyer: one tick against the held state.
// Depends on ipk_pkg.
module ipk_step
    import ipk_pkg::*;
(
    input  cfg_t         cfg,
    input  keyer_ctx_t   cur,
    input  tick_t        tick,
    output keyer_ctx_t   nxt,
    output result_t      res
);

    logic               dit_lvl;
    logic               dah_lvl;
    logic               paddle_src;
    logic               old_is_el;
    logic [PHASE_W-1:0] chosen;
    logic [TMR_W-1:0]   el_len;
    keyer_ctx_t         s;

    always_comb
    begin
        dit_lvl    = cfg.reverse_paddles ? tick.right_level : tick.left_level;
        dah_lvl    = cfg.reverse_paddles ? tick.left_level  : tick.right_level;
        paddle_src = (tick.source_mode[1] == 1'b0);
        old_is_el  = (cur.keyer_phase == PH_DIT) || (cur.keyer_phase == PH_DAH);

        s   = cur;
        res = '{key_level: 1'b0, element_event: EVT_NONE, word_space: 1'b0,
                mode_out: tick.source_mode};

        // sample paddles once the read block has run out
        if (cur.read_block_timer == '0)
        begin
            if (!dah_lvl)
                s.dah_latch = 1'b1;
            if (!dit_lvl)
                s.dit_latch = 1'b1;
        end

        // prefer dah after a dit, dit otherwise
        chosen = PH_UP;
        if (cur.previous_phase == PH_DIT)
        begin
            if (s.dah_latch)
                chosen = PH_DAH;
            else if (s.dit_latch)
                chosen = PH_DIT;
        end
        else
        begin
            if (s.dit_latch)
                chosen = PH_DIT;
            else if (s.dah_latch)
                chosen = PH_DAH;
        end

        el_len = (chosen == PH_DIT)
               ? ({1'b0, cfg.dit_ms} + {{(TMR_W-PTT_W){1'b0}}, cfg.ptt_delay_ms})
               : ({1'b0, cfg.dah_ms} + {{(TMR_W-PTT_W){1'b0}}, cfg.ptt_delay_ms});

        if (paddle_src)
        begin
            if (cur.transition_timer == '0)
            begin
                s.keyer_phase    = old_is_el ? PH_UP : chosen;
                s.previous_phase = old_is_el ? cur.keyer_phase : PH_UP;

                if (!old_is_el && chosen != PH_UP)
                begin
                    res.element_event  = chosen;
                    s.key_state        = 1'b1;
                    s.transition_timer = el_len;
                    s.read_block_timer = el_len;
                    s.dit_latch        = 1'b0;
                    s.dah_latch        = 1'b0;
                    s.word_space_armed = 1'b0;
                    s.word_space_timer = '0;
                end
                else if (!old_is_el)
                begin
                    res.element_event = EVT_CHSPC;
                    res.mode_out      = {1'b0, cfg.reverse_paddles};
                    if (!cur.word_space_armed)
                    begin
                        s.word_space_armed = 1'b1;
                        s.word_space_timer = cfg.dah_ms;
                    end
                end
                else
                begin
                    // element over: key up for one dit gap
                    s.key_state        = 1'b0;
                    s.transition_timer = {1'b0, cfg.dit_ms};
                end
            end
            if (s.word_space_armed && s.word_space_timer == '0)
            begin
                s.word_space_armed = 1'b0;
                res.word_space     = 1'b1;
            end
        end

        res.key_level = s.key_state;

        // all timers step down, stopping at zero
        nxt = s;
        if (s.transition_timer != '0)
            nxt.transition_timer = s.transition_timer - 1'b1;
        if (s.read_block_timer != '0)
            nxt.read_block_timer = s.read_block_timer - 1'b1;
        if (s.word_space_timer != '0)
            nxt.word_space_timer = s.word_space_timer - 1'b1;
    end

endmodule

// File: hdl/iambic_paddle_keyer.sv
// Top level of the iambic paddle keyer: stream ports, configuration
// registers, input and result registers. Depends on ipk_pkg and ipk_step.
//
//  Channel  Signals                       Direction  Meaning
//  s_*      s_tvalid s_tready s_tdata     in         one millisecond tick
//  m_*      m_tvalid m_tready m_tdata     out        one keyer result per tick
//  cfg_*    cfg_we cfg_index cfg_wdata    in         register writes
//
// One item per clock sustained while m_tready stays high. An item taken into the
// input register passes through the step logic into the result register when
// advance allows, where it is offered; the keyer state advances with that load.
// A stall on m_tready holds the result register, and s_tready falls only while
// both the result register and the input register are full and m_tready is low.
// Reset clears the handshake, the keyer state and the registers to their
// defaults; the first transition is due on the 101st tick after reset.
module iambic_paddle_keyer
    import ipk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // left_level, right_level, source_mode[1:0], pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // key_level, element_event[1:0], word_space,
                                             // mode_out[1:0], pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t         cfg_reg;
    keyer_ctx_t   state_reg;
    keyer_ctx_t   state_next;
    tick_t        tick_reg;
    logic         tick_valid_reg;
    result_t      res_reg;
    result_t      res_next;
    logic         res_valid_reg;
    logic         advance;

    // Result register free or being drained: move the held item on.
    assign advance  = !res_valid_reg || m_tready;
    assign s_tready = !tick_valid_reg || advance;

    // Configuration writes, one register per index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{dit_ms: DIT_RESET, dah_ms: DAH_RESET,
                         ptt_delay_ms: PTT_RESET, reverse_paddles: 1'b0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIT:     cfg_reg.dit_ms          <= cfg_wdata[DIT_W-1:0];
                REG_DAH:     cfg_reg.dah_ms          <= cfg_wdata[DAH_W-1:0];
                REG_PTT:     cfg_reg.ptt_delay_ms    <= cfg_wdata[PTT_W-1:0];
                REG_REVERSE: cfg_reg.reverse_paddles <= cfg_wdata[0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: hold the item until the step logic takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (s_tready)
            tick_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            tick_reg <= '{left_level: s_tdata[0], right_level: s_tdata[1],
                          source_mode: s_tdata[3:2]};
    end

    ipk_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .tick (tick_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Keyer state: advance once per item moved into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{keyer_phase: PH_UP, previous_phase: PH_UP,
                           dit_latch: 1'b0, dah_latch: 1'b0,
                           transition_timer: START_DELAY, read_block_timer: '0,
                           word_space_timer: '0, word_space_armed: 1'b0,
                           key_state: 1'b0};
        end
        else if (advance && tick_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= tick_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && tick_valid_reg)
            res_reg <= res_next;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {2'b00, res_reg.mode_out, res_reg.word_space,
                       res_reg.element_event, res_reg.key_level};

    // A started element is always keyed down.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:1] == EVT_DIT || m_tdata[2:1] == EVT_DAH)
        |-> m_tdata[0])
        else $error("element started without key down");

    // A word space only comes from a paddle source, so mode_out is 0 or 1.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[5])
        else $error("word space reported outside paddle mode");

    // While an element phase runs the transmitter stays keyed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.keyer_phase == PH_DIT || state_reg.keyer_phase == PH_DAH)
        |-> state_reg.key_state)
        else $error("element phase with key up");

    // State moves only when an item is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && tick_valid_reg) |=> $stable(state_reg))
        else $error("keyer state changed without an item");

endmodule
